>>> hdl/tlo_pkg.sv
`default_nettype none

package tlo_pkg;

   // Block geometry
   localparam int GLYPH_WIDTH   = 8;
   localparam int GLYPH_HEIGHT  = 16;
   localparam int TEXT_LENGTH   = 20;
   localparam int GLYPH_COUNT   = 13;
   localparam int MAX_DIMENSION = 4096;

   // Field widths
   localparam int MODE_W     = 2;
   localparam int LUMA_W     = 8;
   localparam int DIM_W      = 13;
   localparam int MARGIN_W   = 12;
   localparam int COUNT_W    = 12;
   localparam int CHAR_W     = 8;
   localparam int TPOS_W     = 5;
   localparam int GNUM_W     = 4;
   localparam int GROW_W     = 4;
   localparam int ROWBITS_W  = 8;

   // Register port
   localparam int CSR_COUNT  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   // Derived
   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
   localparam int SLOT_W      = $clog2(TEXT_LENGTH);
   localparam int ROW_W       = $clog2(GLYPH_HEIGHT);
   localparam int COLK_W      = $clog2(GLYPH_WIDTH);
   localparam int K_W         = (COLK_W > 3) ? COLK_W : 3;
   localparam int BOX_W       = TEXT_LENGTH * GLYPH_WIDTH;
   localparam int BOX_HALF    = (TEXT_LENGTH / 2) * GLYPH_WIDTH;
   localparam int DXB_W       = $clog2(BOX_W);
   localparam int SPOS_W      = DIM_W + 2;

   // Column-in-box to slot: multiply by reciprocal, exact for dx < 2**DXB_W
   localparam int RCP_SHIFT = DXB_W + COLK_W + 1;
   localparam int RCP_W     = RCP_SHIFT + 1;
   localparam int RCP       = (2 ** RCP_SHIFT + GLYPH_WIDTH - 1) / GLYPH_WIDTH;
   localparam int PROD_W    = DXB_W + RCP_W;

   localparam logic [GLYPH_W-1:0] DASH_GLYPH  = GLYPH_W'(10);
   localparam logic [GLYPH_W-1:0] BLANK_GLYPH = GLYPH_W'(11);
   localparam logic [GLYPH_W-1:0] COLON_GLYPH = GLYPH_W'(12);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

   typedef enum logic [MODE_W-1:0] {
      MODE_PIXEL = 2'd0,
      MODE_TEXT  = 2'd1,
      MODE_GLYPH = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_BOTTOM_MARGIN = 2'd2,
      CSR_TEXT_LUMA     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]         w_eff;
      logic [DIM_W-1:0]         h_eff;
      logic signed [SPOS_W-1:0] box_top;
      logic signed [SPOS_W-1:0] box_left;
   } geom_type;

   typedef struct packed {
      logic             win;
      logic [DXB_W-1:0] dx;
      logic [ROW_W-1:0] dy;
   } loc_type;

   typedef struct packed {
      logic                 text_we;
      logic [SLOT_W-1:0]    text_pos;
      logic [GLYPH_W-1:0]   text_glyph;
      logic                 glyph_we;
      logic [ADDR_W-1:0]    glyph_addr;
      logic [ROWBITS_W-1:0] row_bits;
   } font_wr_type;

   typedef struct packed {
      logic              is_pixel;
      loc_type           loc;
      logic [LUMA_W-1:0] luma;
      font_wr_type       wr;
   } stage_type;

   function automatic logic [GLYPH_W-1:0] map_char(input logic [CHAR_W-1:0] code);
      logic [GLYPH_W-1:0] g;
      g = BLANK_GLYPH;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         g = GLYPH_W'(code - CHAR_ZERO);
      end else if (code == CHAR_DASH) begin
         g = DASH_GLYPH;
      end else if (code == CHAR_COLON) begin
         g = COLON_GLYPH;
      end
      return g;
   endfunction

endpackage

`default_nettype wire

>>> hdl/tlo_req_if.sv
`default_nettype none

interface tlo_req_if;
   import tlo_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic                 frame_start;
   logic [LUMA_W-1:0]    luma_in;
   logic [TPOS_W-1:0]    text_position;
   logic [CHAR_W-1:0]    char_code;
   logic [GNUM_W-1:0]    glyph_number;
   logic [GROW_W-1:0]    glyph_row;
   logic [ROWBITS_W-1:0] row_bits;

   modport source (
      output valid, mode, frame_start, luma_in, text_position, char_code,
             glyph_number, glyph_row, row_bits,
      input  ready
   );

   modport sink (
      input  valid, mode, frame_start, luma_in, text_position, char_code,
             glyph_number, glyph_row, row_bits,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/tlo_rsp_if.sv
`default_nettype none

interface tlo_rsp_if;
   import tlo_pkg::*;

   logic              valid;
   logic              ready;
   logic [LUMA_W-1:0] luma_out;
   logic              text_hit;

   modport source (
      output valid, luma_out, text_hit,
      input  ready
   );

   modport sink (
      input  valid, luma_out, text_hit,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/timestamp_text_luma_overlay_unit.sv
// Timestamp text overlay on a raster luma stream.
// req channel (valid/ready): one transaction per pixel or per load command.
//   mode pixel: luma_in in raster order; frame_start restarts column/row at 0.
//   mode text:  writes a character code into one of the text slots.
//   mode glyph: writes one bitmap row of one glyph.
// rsp channel (valid/ready): one transaction per pixel, luma_out and text_hit;
//   load commands and unused modes produce nothing.
// APB port: frame_width, frame_height, bottom_margin, text_luma at 0x0/4/8/C.
//   Write only while the stream is idle.
// Throughput: one transaction per clock while rsp is not stalled; the
//   five-stage pipeline (position, slot divide, glyph RAM read, pixel select,
//   output register) all advance together.
// Stall: when rsp holds an untaken result and rsp.ready is low the whole
//   pipeline freezes and req.ready drops in the same cycle; nothing is lost.
// Reset: clears the pipeline, the raster position and all text slots to
//   blank and loads the register defaults. Glyph RAM is not cleared: load
//   every glyph row that the text will show before streaming pixels.
`default_nettype none

module timestamp_text_luma_overlay_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tlo_req_if.sink                                req,
   tlo_rsp_if.source                              rsp,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tlo_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [tlo_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [tlo_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);
   import tlo_pkg::*;

   geom_type             geom;
   logic [LUMA_W-1:0]    text_luma;
   loc_type              loc;
   logic [ROWBITS_W-1:0] font_bits;

   // global advance: everything moves unless a result waits on the receiver
   logic pipe_en;

   // stage 0: input register
   logic                 s0_valid_ff;
   logic [MODE_W-1:0]    s0_mode_ff;
   logic                 s0_frame_start_ff;
   logic [LUMA_W-1:0]    s0_luma_ff;
   logic [TPOS_W-1:0]    s0_text_position_ff;
   logic [CHAR_W-1:0]    s0_char_code_ff;
   logic [GNUM_W-1:0]    s0_glyph_number_ff;
   logic [GROW_W-1:0]    s0_glyph_row_ff;
   logic [ROWBITS_W-1:0] s0_row_bits_ff;

   // stages 1, 2: decoded item
   stage_type            s1_in;
   stage_type            s1_ff;
   logic                 s1_valid_ff;
   stage_type            s2_ff;
   logic                 s2_valid_ff;
   logic [SLOT_W-1:0]    slot_in;
   logic [SLOT_W-1:0]    slot_ff;
   logic [PROD_W-1:0]    slot_prod;

   // stage 3: glyph row read back
   font_wr_type          font_wr;
   logic [DXB_W-1:0]     k_full;
   logic                 s3_valid_ff;
   logic                 s3_win_ff;
   logic [K_W-1:0]       s3_k_ff;
   logic [LUMA_W-1:0]    s3_luma_ff;
   logic                 draw;

   // output register
   logic                 rsp_valid_ff;
   logic [LUMA_W-1:0]    luma_out_ff;
   logic                 text_hit_ff;

   assign pipe_en   = !rsp_valid_ff || rsp.ready;
   assign req.ready = pipe_en;

   tlo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .geom      (geom),
      .text_luma (text_luma)
   );

   // ---------------- stage 0 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_mode_ff          <= req.mode;
         s0_frame_start_ff   <= req.frame_start;
         s0_luma_ff          <= req.luma_in;
         s0_text_position_ff <= req.text_position;
         s0_char_code_ff     <= req.char_code;
         s0_glyph_number_ff  <= req.glyph_number;
         s0_glyph_row_ff     <= req.glyph_row;
         s0_row_bits_ff      <= req.row_bits;
      end
   end

   // raster position is tracked here, ahead of everything else
   tlo_locate u_locate (
      .clock       (clock),
      .reset       (reset),
      .step        (pipe_en && s0_valid_ff && (s0_mode_ff == MODE_PIXEL)),
      .frame_start (s0_frame_start_ff),
      .geom        (geom),
      .loc         (loc)
   );

   always_comb begin
      s1_in.is_pixel      = (s0_mode_ff == MODE_PIXEL);
      s1_in.loc           = loc;
      s1_in.luma          = s0_luma_ff;
      s1_in.wr.text_we    = (s0_mode_ff == MODE_TEXT)
                            && (int'(s0_text_position_ff) < TEXT_LENGTH);
      s1_in.wr.text_pos   = SLOT_W'(s0_text_position_ff);
      s1_in.wr.text_glyph = map_char(s0_char_code_ff);
      s1_in.wr.glyph_we   = (s0_mode_ff == MODE_GLYPH)
                            && (int'(s0_glyph_number_ff) < GLYPH_COUNT)
                            && (int'(s0_glyph_row_ff) < GLYPH_HEIGHT);
      s1_in.wr.glyph_addr = ADDR_W'(int'(s0_glyph_number_ff) * GLYPH_HEIGHT
                                    + int'(s0_glyph_row_ff));
      s1_in.wr.row_bits   = s0_row_bits_ff;
   end

   // ---------------- stage 1: slot = dx / GLYPH_WIDTH ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign slot_prod = PROD_W'(s1_ff.loc.dx) * PROD_W'(RCP);
   assign slot_in   = slot_prod[RCP_SHIFT +: SLOT_W];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ff   <= s1_in;
         s2_ff   <= s1_ff;
         slot_ff <= slot_in;
      end
   end

   // ---------------- stage 2: text slot and glyph RAM access ----------------
   // loads take effect here too, so pixels see them in transaction order
   always_comb begin
      font_wr          = s2_ff.wr;
      font_wr.text_we  = s2_ff.wr.text_we && s2_valid_ff && pipe_en;
      font_wr.glyph_we = s2_ff.wr.glyph_we && s2_valid_ff && pipe_en;
   end

   assign k_full = DXB_W'(int'(s2_ff.loc.dx) - int'(slot_ff) * GLYPH_WIDTH);

   tlo_font u_font (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (pipe_en),
      .wr       (font_wr),
      .rd_slot  (slot_ff),
      .rd_dy    (s2_ff.loc.dy),
      .row_bits (font_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= s2_valid_ff && s2_ff.is_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_win_ff  <= s2_ff.loc.win;
         s3_k_ff    <= K_W'(k_full);
         s3_luma_ff <= s2_ff.luma;
      end
   end

   // ---------------- stage 3: pick the glyph bit ----------------
   // columns past the eighth of a wide glyph never draw
   assign draw = s3_win_ff && ((s3_k_ff >> 3) == '0) && font_bits[s3_k_ff[2:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         luma_out_ff <= draw ? text_luma : s3_luma_ff;
         text_hit_ff <= draw;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.luma_out = luma_out_ff;
   assign rsp.text_hit = text_hit_ff;

endmodule

`default_nettype wire

>>> hdl/tlo_csr.sv
`default_nettype none

module tlo_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tlo_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [tlo_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [tlo_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready,
   output tlo_pkg::geom_type                      geom,
   output logic      [tlo_pkg::LUMA_W-1:0]        text_luma
);
   import tlo_pkg::*;

   logic [DIM_W-1:0]    frame_width_ff;
   logic [DIM_W-1:0]    frame_height_ff;
   logic [MARGIN_W-1:0] bottom_margin_ff;
   logic [LUMA_W-1:0]   text_luma_ff;
   geom_type            geom_ff;
   geom_type            geom_in;
   csr_index_type       index;
   logic                wr_en;
   logic [DIM_W-1:0]    w_eff;
   logic [DIM_W-1:0]    h_eff;

   assign index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= DIM_W'(1920);
         frame_height_ff  <= DIM_W'(1080);
         bottom_margin_ff <= MARGIN_W'(30);
         text_luma_ff     <= LUMA_W'(235);
      end else if (wr_en) begin
         case (index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= pwdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= pwdata[DIM_W-1:0];
            CSR_BOTTOM_MARGIN: bottom_margin_ff <= pwdata[MARGIN_W-1:0];
            CSR_TEXT_LUMA:     text_luma_ff     <= pwdata[LUMA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_FRAME_WIDTH:   prdata = CSR_DATA_W'(frame_width_ff);
         CSR_FRAME_HEIGHT:  prdata = CSR_DATA_W'(frame_height_ff);
         CSR_BOTTOM_MARGIN: prdata = CSR_DATA_W'(bottom_margin_ff);
         CSR_TEXT_LUMA:     prdata = CSR_DATA_W'(text_luma_ff);
         default:           prdata = '0;
      endcase
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (frame_width_ff > DIM_W'(MAX_DIMENSION)) begin
         w_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (frame_height_ff > DIM_W'(MAX_DIMENSION)) begin
         h_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         h_eff = frame_height_ff;
      end
      geom_in.w_eff    = w_eff;
      geom_in.h_eff    = h_eff;
      geom_in.box_top  = $signed(SPOS_W'(h_eff) - SPOS_W'(GLYPH_HEIGHT)
                                 - SPOS_W'(bottom_margin_ff));
      geom_in.box_left = $signed(SPOS_W'(w_eff >> 1) - SPOS_W'(BOX_HALF));
   end

   // box placement is re-derived every cycle; the user must change registers only while idle (not enforced)
   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom      = geom_ff;
   assign text_luma = text_luma_ff;

endmodule

`default_nettype wire

>>> hdl/tlo_locate.sv
`default_nettype none

module tlo_locate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              frame_start,
   input  tlo_pkg::geom_type      geom,
   output tlo_pkg::loc_type       loc
);
   import tlo_pkg::*;

   localparam logic signed [SPOS_W-1:0] BOX_LIMIT = SPOS_W'(BOX_W);
   localparam logic signed [SPOS_W-1:0] ROW_LIMIT = SPOS_W'(GLYPH_HEIGHT);

   logic [COUNT_W-1:0]       col_ff;
   logic [COUNT_W-1:0]       row_ff;
   logic [COUNT_W-1:0]       col_in;
   logic [COUNT_W-1:0]       row_in;
   logic [COUNT_W-1:0]       col_cur;
   logic [COUNT_W-1:0]       row_cur;
   logic [COUNT_W-1:0]       col_inc;
   logic [COUNT_W-1:0]       row_inc;
   logic signed [SPOS_W-1:0] dx;
   logic signed [SPOS_W-1:0] dy;

   assign col_cur = frame_start ? '0 : col_ff;
   assign row_cur = frame_start ? '0 : row_ff;

   assign dx = $signed(SPOS_W'(col_cur)) - geom.box_left;
   assign dy = $signed(SPOS_W'(row_cur)) - geom.box_top;

   always_comb begin
      loc.win = (DIM_W'(col_cur) < geom.w_eff) && (DIM_W'(row_cur) < geom.h_eff)
                && !dx[SPOS_W-1] && (dx < BOX_LIMIT)
                && !dy[SPOS_W-1] && (dy < ROW_LIMIT);
      loc.dx  = dx[DXB_W-1:0];
      loc.dy  = dy[ROW_W-1:0];
   end

   // raster advance, wrapping at the clamped frame size or on counter rollover
   always_comb begin
      col_inc = col_cur + COUNT_W'(1);
      row_inc = row_cur + COUNT_W'(1);
      col_in  = col_inc;
      row_in  = row_cur;
      if ((DIM_W'(col_inc) >= geom.w_eff) || (col_inc == '0)) begin
         col_in = '0;
         row_in = (DIM_W'(row_inc) >= geom.h_eff) ? '0 : row_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/tlo_font.sv
`default_nettype none

module tlo_font (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rd_en,
   input  tlo_pkg::font_wr_type                 wr,
   input  wire logic [tlo_pkg::SLOT_W-1:0]      rd_slot,
   input  wire logic [tlo_pkg::ROW_W-1:0]       rd_dy,
   output logic      [tlo_pkg::ROWBITS_W-1:0]   row_bits
);
   import tlo_pkg::*;

   logic [GLYPH_W-1:0]   text_ff [TEXT_LENGTH];
   logic [ROWBITS_W-1:0] glyph_mem [STORE_DEPTH];
   logic [ROWBITS_W-1:0] row_bits_ff;
   logic [GLYPH_W-1:0]   glyph_sel;
   logic [ADDR_W-1:0]    rd_addr;

   // slot index past the line only shows up outside the text box
   assign glyph_sel = (int'(rd_slot) < TEXT_LENGTH) ? text_ff[rd_slot] : BLANK_GLYPH;
   assign rd_addr   = ADDR_W'(int'(glyph_sel) * GLYPH_HEIGHT + int'(rd_dy));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TEXT_LENGTH; i++) begin
            text_ff[i] <= BLANK_GLYPH;
         end
      end else if (wr.text_we) begin
         text_ff[wr.text_pos] <= wr.text_glyph;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.glyph_we) begin
         glyph_mem[wr.glyph_addr] <= wr.row_bits;
      end
      if (rd_en) begin
         row_bits_ff <= glyph_mem[rd_addr];
      end
   end

   assign row_bits = row_bits_ff;

endmodule

`default_nettype wire

>>> hdl/tlo_checker.sv
`default_nettype none

module tlo_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [tlo_pkg::LUMA_W-1:0]    luma_out,
   input wire logic                          text_hit
);
   import tlo_pkg::*;

   // a waiting result keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(luma_out) && $stable(text_hit))
      else $error("rsp changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // input is taken exactly when the output stage can move
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req ready does not track output stage");

   // no pixel can reach the output before it has crossed the pipeline
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid, 5) || $past(rsp_valid, 2) ||
                           $past(rsp_valid, 3) || $past(rsp_valid, 4) ||
                           $past(rsp_valid, 5) || $past(req_valid, 6) ||
                           !$past(req_ready, 1))
      else $error("rsp appeared without a matching pixel");

endmodule

bind timestamp_text_luma_overlay_unit tlo_checker u_tlo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .luma_out  (rsp.luma_out),
   .text_hit  (rsp.text_hit)
);

`default_nettype wire
